@@ hdl/hsl_pkg.sv @@
// Shared constants and types for the HSL lightness / hue adjuster.
// No dependencies; used by every module in hdl/.
package hsl_pkg;

    localparam int FRAC_BITS_DEF = 16;  // default fraction width of l, s and hue
    localparam int PIX_W         = 8;   // color channel width
    localparam int DELTA_W       = 18;  // lightness offset register width
    localparam int CFG_IDX_W     = 1;   // configuration index width
    localparam int DIV_W         = 11;  // divider operand width (6 * 255 fits)

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 1'b0,
        CFG_DELTA = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        MODE_LIGHTEN = 1'b0,
        MODE_INVERT  = 1'b1
    } t_mode;

endpackage

@@ hdl/hsl_div.sv @@
// Pipelined restoring divider: quo = floor(num * 2^FRAC_BITS / den), num <= den.
// One quotient bit per stage, FRAC_BITS + 1 stages. Uses hsl_pkg.
module hsl_div #(
    parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [hsl_pkg::DIV_W-1:0] i_num,
    input  logic [hsl_pkg::DIV_W-1:0] i_den,
    output logic [FRAC_BITS:0]   o_quo
);
    localparam int W = hsl_pkg::DIV_W;
    localparam int Q = FRAC_BITS + 1;

    logic [W-1:0] r_rem [Q];
    logic [W-1:0] r_den [Q];
    logic [Q-1:0] r_quo [Q];

    genvar k;
    generate
        for (k = 0; k < Q; k++) begin : g_stage
            if (k == 0) begin : g_first
                logic         w_ge;
                logic [W-1:0] w_sub;
                assign w_ge  = i_num >= i_den;
                assign w_sub = i_num - i_den;
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[0] <= w_ge ? w_sub : i_num;
                        r_den[0] <= i_den;
                        r_quo[0] <= {{(Q-1){1'b0}}, w_ge};
                    end
                end
            end else begin : g_next
                logic [W:0] w_sh;
                logic [W:0] w_sub;
                logic       w_ge;
                assign w_sh  = {r_rem[k-1], 1'b0};
                assign w_ge  = w_sh >= {1'b0, r_den[k-1]};
                assign w_sub = w_sh - {1'b0, r_den[k-1]};
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k] <= w_ge ? w_sub[W-1:0] : w_sh[W-1:0];
                        r_den[k] <= r_den[k-1];
                        r_quo[k] <= {r_quo[k-1][Q-2:0], w_ge};
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[Q-1];

endmodule

@@ hdl/hsl_chan.sv @@
// One output channel of the HSL to RGB conversion, four register stages:
// segment select, ramp product, value, scale to 8 bits. Uses hsl_pkg.
module hsl_chan #(
    parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [FRAC_BITS:0]  i_t,
    input  logic [FRAC_BITS:0]  i_t1,
    input  logic [FRAC_BITS:0]  i_t2,
    output hsl_pkg::t_pix       o_val
);
    localparam int QW = FRAC_BITS + 1;
    localparam int TW = QW + 3;
    localparam logic [QW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0] HALF = ONE >> 1;

    typedef enum logic [2:0] {
        SEG_RAMP = 3'b001,
        SEG_HI   = 3'b010,
        SEG_LO   = 3'b100
    } t_seg;

    logic [TW-1:0]   w_t6;
    logic [QW+1:0]   w_t3;
    logic [TW-1:0]   w_fall;
    logic [QW-1:0]   n_f;
    t_seg            n_sel;

    t_seg            ra_sel;
    logic [QW-1:0]   ra_f, ra_dif, ra_t1, ra_t2;
    t_seg            rb_sel;
    logic [2*QW-1:0] rb_p;
    logic [QW-1:0]   rb_t1, rb_t2;
    logic [QW:0]     w_ramp;
    logic [QW-1:0]   n_v;
    logic [QW-1:0]   r_v;
    logic [QW+7:0]   w_scl;
    hsl_pkg::t_pix   r_o;

    assign w_t6   = ({3'b000, i_t} << 2) + ({3'b000, i_t} << 1);
    assign w_t3   = ({2'b00, i_t} << 1) + {2'b00, i_t};
    assign w_fall = ({3'b000, ONE} << 2) - w_t6;

    always_comb begin
        n_f   = '0;
        n_sel = SEG_LO;
        if (w_t6 < {3'b000, ONE}) begin
            n_f   = w_t6[QW-1:0];
            n_sel = SEG_RAMP;
        end else if (i_t < HALF) begin
            n_sel = SEG_HI;
        end else if (w_t3 < {1'b0, ONE, 1'b0}) begin
            n_f   = w_fall[QW-1:0];
            n_sel = SEG_RAMP;
        end
    end

    assign w_ramp = {1'b0, rb_t2} + {1'b0, rb_p[FRAC_BITS +: QW]};

    always_comb begin
        case (rb_sel)
            SEG_RAMP: n_v = (w_ramp > {1'b0, ONE}) ? ONE : w_ramp[QW-1:0];
            SEG_HI:   n_v = rb_t1;
            SEG_LO:   n_v = rb_t2;
            default:  n_v = rb_t2;
        endcase
    end

    assign w_scl = {r_v, 8'd0} - {8'd0, r_v};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_sel <= n_sel;
            ra_f   <= n_f;
            ra_dif <= i_t1 - i_t2;
            ra_t1  <= i_t1;
            ra_t2  <= i_t2;
            rb_sel <= ra_sel;
            rb_p   <= ra_dif * ra_f;
            rb_t1  <= ra_t1;
            rb_t2  <= ra_t2;
            r_v    <= n_v;
            r_o    <= w_scl[FRAC_BITS +: 8];
        end
    end

    assign o_val = r_o;

endmodule

@@ hdl/hsl_lightness_hue_adjust.sv @@
// Top level of the HSL lightness / hue adjuster: RGB -> HSL -> adjust -> RGB.
// Depends on hsl_pkg, hsl_div and hsl_chan.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready     | i_red_in, i_green_in, i_blue_in
//  output   | o_out_valid / i_out_ready   | o_red_out, o_green_out, o_blue_out
//  config   | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// One item enters per cycle while the pipeline advances; the pipeline depth is set by the
// FRAC_BITS + 1 stage dividers for saturation and hue. Lightness rides a
// matching delay line and ends in a reciprocal multiply by 1/510.
// Reset (synchronous, active low) clears the valid bits and the configuration registers.
// The whole pipeline advances together; it holds only when the output
// register is full and i_out_ready is low, so nothing is lost or repeated.
module hsl_lightness_hue_adjust #(
    parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hsl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hsl_pkg::DELTA_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hsl_pkg::t_pix                     i_red_in,
    input  hsl_pkg::t_pix                     i_green_in,
    input  hsl_pkg::t_pix                     i_blue_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hsl_pkg::t_pix                     o_red_out,
    output hsl_pkg::t_pix                     o_green_out,
    output hsl_pkg::t_pix                     o_blue_out
);
    localparam int QW  = FRAC_BITS + 1;
    localparam int DW  = hsl_pkg::DIV_W;
    localparam int DLW = hsl_pkg::DELTA_W;
    localparam int LAT = FRAC_BITS + 11;
    localparam int LSW = ((QW + 1 > DLW) ? QW + 1 : DLW) + 1;
    localparam int THIRD_I = (1 << FRAC_BITS) / 3;
    localparam logic [QW-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0] HALF  = ONE >> 1;
    localparam logic [QW-1:0] THIRD = QW'(THIRD_I);
    // floor(sum * 2^FRAC_BITS / 510) = (sum * LMUL) >> LSH for every sum up to 510
    localparam int LSH = 20;
    localparam int LMW = FRAC_BITS + 12;
    localparam logic [LMW-1:0] LMUL =
        LMW'(((64'd1 << (FRAC_BITS + LSH)) + 64'd509) / 64'd510);

    // configuration registers
    hsl_pkg::t_mode              r_mode;
    logic signed [DLW-1:0]       r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hsl_pkg::MODE_LIGHTEN;
            r_delta <= '0;
        end else if (i_cfg_we) begin
            case (hsl_pkg::t_cfg_idx'(i_cfg_idx))
                hsl_pkg::CFG_MODE:  r_mode  <= hsl_pkg::t_mode'(i_cfg_data[0]);
                hsl_pkg::CFG_DELTA: r_delta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: move everything unless the output item is stalled
    logic           w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv      = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // stage 1: capture the pixel
    hsl_pkg::t_pix r1_r, r1_g, r1_b;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_r <= i_red_in;
            r1_g <= i_green_in;
            r1_b <= i_blue_in;
        end
    end

    // stage 2: max, min, spread, saturation denominator, hue numerator
    hsl_pkg::t_pix w_mx, w_mn, w_d, w_den;
    logic [8:0]    w_sum;
    logic [11:0]   w_n, w_d6;
    logic [8:0]    w_sum_hi;

    always_comb begin
        if (r1_r >= r1_g && r1_r >= r1_b) begin
            w_mx = r1_r;
        end else if (r1_g >= r1_b) begin
            w_mx = r1_g;
        end else begin
            w_mx = r1_b;
        end
        w_mn = r1_r;
        if (r1_g < w_mn) w_mn = r1_g;
        if (r1_b < w_mn) w_mn = r1_b;
    end

    assign w_d      = w_mx - w_mn;
    assign w_sum    = {1'b0, w_mx} + {1'b0, w_mn};
    assign w_sum_hi = 9'd510 - w_sum;
    assign w_den    = (w_sum <= 9'd255) ? w_sum[7:0] : w_sum_hi[7:0];
    assign w_d6     = {2'b00, w_d, 2'b00} + {3'b000, w_d, 1'b0};

    // red wins ties, then green; a negative red sector wraps by 6d
    always_comb begin
        if (r1_r >= r1_g && r1_r >= r1_b) begin
            w_n = {4'd0, r1_g} - {4'd0, r1_b};
            if (r1_g < r1_b) w_n = w_n + w_d6;
        end else if (r1_g >= r1_b) begin
            w_n = {3'd0, w_d, 1'b0} + {4'd0, r1_b} - {4'd0, r1_r};
        end else begin
            w_n = {2'd0, w_d, 2'd0} + {4'd0, r1_r} - {4'd0, r1_g};
        end
    end

    logic [8:0]    r2_sum;
    hsl_pkg::t_pix r2_d, r2_den;
    logic [DW-1:0] r2_n, r2_d6;
    logic          r2_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sum  <= w_sum;
            r2_d    <= w_d;
            r2_den  <= w_den;
            r2_n    <= w_n[DW-1:0];
            r2_d6   <= w_d6[DW-1:0];
            r2_grey <= (w_d == 8'd0);
        end
    end

    // dividers: saturation, hue
    logic [QW-1:0] w_sq, w_hq;

    hsl_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num ({{(DW-8){1'b0}}, r2_d}), .i_den ({{(DW-8){1'b0}}, r2_den}),
        .o_quo (w_sq)
    );
    hsl_div #(.FRAC_BITS(FRAC_BITS)) u_div_h (
        .i_clk (i_clk), .i_en (w_adv),
        .i_num (r2_n), .i_den (r2_d6), .o_quo (w_hq)
    );

    // lightness: delay the channel sum, then scale by 1/510 in the last step
    logic [8:0]     r_sumd [QW-1];
    logic [LMW+8:0] w_lprod;
    logic [QW-1:0]  r_lq;

    assign w_lprod = {{LMW{1'b0}}, r_sumd[QW-2]} * {9'd0, LMUL};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sumd[0] <= r2_sum;
            for (int k = 1; k < QW - 1; k++) begin
                r_sumd[k] <= r_sumd[k-1];
            end
            r_lq <= w_lprod[LSH +: QW];
        end
    end

    // carry the grey flag alongside the dividers
    logic [QW-1:0] r_gd;

    always_ff @(posedge i_clk) begin
        if (w_adv) r_gd <= {r_gd[QW-2:0], r2_grey};
    end

    // stage 3: lighten/darken with clamp, or rotate hue by half a circle
    logic signed [LSW-1:0] w_lsum;
    logic [QW-1:0]         n_l;
    logic [FRAC_BITS-1:0]  n_h;

    assign w_lsum = $signed({{(LSW-QW){1'b0}}, r_lq})
                  + $signed({{(LSW-DLW){r_delta[DLW-1]}}, r_delta});

    always_comb begin
        n_l = r_lq;
        n_h = w_hq[FRAC_BITS-1:0];
        if (r_mode == hsl_pkg::MODE_LIGHTEN) begin
            if (w_lsum[LSW-1]) begin
                n_l = '0;
            end else if (w_lsum > $signed({{(LSW-QW){1'b0}}, ONE})) begin
                n_l = ONE;
            end else begin
                n_l = w_lsum[QW-1:0];
            end
        end else begin
            n_h[FRAC_BITS-1] = ~w_hq[FRAC_BITS-1];
        end
    end

    logic [QW-1:0]        r3_l, r3_s;
    logic [FRAC_BITS-1:0] r3_h;
    logic                 r3_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_l    <= n_l;
            r3_s    <= w_sq;
            r3_h    <= n_h;
            r3_grey <= r_gd[QW-1];
        end
    end

    // stage 4: l * s
    logic [2*QW-1:0]      r4_ls;
    logic [QW-1:0]        r4_l, r4_s;
    logic [FRAC_BITS-1:0] r4_h;
    logic                 r4_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_ls   <= r3_l * r3_s;
            r4_l    <= r3_l;
            r4_s    <= r3_s;
            r4_h    <= r3_h;
            r4_grey <= r3_grey;
        end
    end

    // stage 5: t1, t2, per-channel hue positions, grey level
    logic [QW-1:0] w_lsf, w_tr, w_trw, w_tg, w_tb;
    logic [QW:0]   w_t1;
    logic [QW+1:0] w_t2;
    logic [QW+7:0] w_gscl;

    assign w_lsf = r4_ls[FRAC_BITS +: QW];
    assign w_t1  = (r4_l < HALF) ? ({1'b0, r4_l} + {1'b0, w_lsf})
                                 : ({1'b0, r4_l} + {1'b0, r4_s} - {1'b0, w_lsf});
    assign w_t2  = {1'b0, r4_l, 1'b0} - {1'b0, w_t1};
    assign w_tr  = {1'b0, r4_h} + THIRD;
    assign w_trw = (w_tr > ONE) ? (w_tr - ONE) : w_tr;
    assign w_tg  = {1'b0, r4_h};
    assign w_tb  = ({1'b0, r4_h} < THIRD) ? ({1'b0, r4_h} + ONE - THIRD)
                                          : ({1'b0, r4_h} - THIRD);
    assign w_gscl = {r4_l, 8'd0} - {8'd0, r4_l};

    logic [QW-1:0] r5_t1, r5_t2, r5_tr, r5_tg, r5_tb;
    logic          r5_grey;
    hsl_pkg::t_pix r5_gv;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_t1   <= w_t1[QW-1:0];
            r5_t2   <= w_t2[QW+1] ? '0 : w_t2[QW-1:0];
            r5_tr   <= w_trw;
            r5_tg   <= w_tg;
            r5_tb   <= w_tb;
            r5_grey <= r4_grey;
            r5_gv   <= w_gscl[FRAC_BITS +: 8];
        end
    end

    // stages 6..9: channel values
    hsl_pkg::t_pix w_ro, w_go, w_bo;

    hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_r (
        .i_clk (i_clk), .i_en (w_adv), .i_t (r5_tr),
        .i_t1 (r5_t1), .i_t2 (r5_t2), .o_val (w_ro)
    );
    hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_g (
        .i_clk (i_clk), .i_en (w_adv), .i_t (r5_tg),
        .i_t1 (r5_t1), .i_t2 (r5_t2), .o_val (w_go)
    );
    hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_b (
        .i_clk (i_clk), .i_en (w_adv), .i_t (r5_tb),
        .i_t1 (r5_t1), .i_t2 (r5_t2), .o_val (w_bo)
    );

    // delay the grey path to match the channel stages
    logic [3:0]    r_gyd;
    hsl_pkg::t_pix r_gvd [4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_gyd    <= {r_gyd[2:0], r5_grey};
            r_gvd[0] <= r5_gv;
            r_gvd[1] <= r_gvd[0];
            r_gvd[2] <= r_gvd[1];
            r_gvd[3] <= r_gvd[2];
        end
    end

    // output register: grey pixels bypass the hue math
    hsl_pkg::t_pix r_out_r, r_out_g, r_out_b;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_r <= r_gyd[3] ? r_gvd[3] : w_ro;
            r_out_g <= r_gyd[3] ? r_gvd[3] : w_go;
            r_out_b <= r_gyd[3] ? r_gvd[3] : w_bo;
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_red_out   = r_out_r;
    assign o_green_out = r_out_g;
    assign o_blue_out  = r_out_b;

endmodule

@@ hdl/hsl_chk.sv @@
// Port-level checks for hsl_lightness_hue_adjust, attached by bind.
// Depends on hsl_pkg.
module hsl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input hsl_pkg::t_pix                 o_red_out,
    input hsl_pkg::t_pix                 o_green_out,
    input hsl_pkg::t_pix                 o_blue_out
);

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an empty output stage never back-pressures the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out))
        else $error("stalled output payload changed");

endmodule

bind hsl_lightness_hue_adjust hsl_chk u_hsl_chk (.*);

@@ sim/hsl_lightness_hue_adjust_test.sv @@
// Self-checking testbench for the HSL lightness / hue adjuster.
// Depends on hsl_pkg and the hsl_lightness_hue_adjust RTL; stands alone otherwise.
// Drives pixels under random idling on both sides and checks every output pixel.
module hsl_lightness_hue_adjust_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB       = hsl_pkg::FRAC_BITS_DEF;
    localparam longint ONE  = 64'sd1 << FB;
    localparam int LATENCY  = FB + 11;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        hsl_pkg::t_pix red;
        hsl_pkg::t_pix green;
        hsl_pkg::t_pix blue;
    } t_rgb;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [hsl_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [hsl_pkg::DELTA_W-1:0]   i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    hsl_pkg::t_pix                 i_red_in, i_green_in, i_blue_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    hsl_pkg::t_pix                 o_red_out, o_green_out, o_blue_out;

    hsl_lightness_hue_adjust DUT (.*);

    // Mirror of the adjust registers, updated whenever the testbench writes one.
    hsl_pkg::t_mode cur_mode;
    longint  cur_delta;

    t_rgb    expected_pixels[$];
    int      error_count;
    longint  cycle_count;
    bit      sink_idle_on;     // random output stalls enabled
    bit      src_idle_on;      // random input gaps enabled
    int      sink_hold_cycles; // long output stall requested by a test

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Timeout watchdog.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAIL hsl_lightness_hue_adjust");
                $finish;
            end
        end
    end

    // One hue segment of the HSL-to-RGB conversion.
    function automatic hsl_pkg::t_pix hue_to_channel(longint t, longint t1, longint t2);
        longint v;
        if (t < 0) t += ONE;
        else if (t > ONE) t -= ONE;
        if (6 * t < ONE)          v = t2 + (((t1 - t2) * 6 * t) >>> FB);
        else if (2 * t < ONE)     v = t1;
        else if (3 * t < 2 * ONE) v = t2 + (((t1 - t2) * (4 * ONE - 6 * t)) >>> FB);
        else                      v = t2;
        if (v < 0) v = 0;
        if (v > ONE) v = ONE;
        return hsl_pkg::t_pix'((v * 255) >>> FB);
    endfunction

    // Predict the adjusted pixel for one source pixel under the current registers.
    function automatic t_rgb adjust_pixel(hsl_pkg::t_pix r8, hsl_pkg::t_pix g8,
                                          hsl_pkg::t_pix b8);
        longint r, g, b, mx, mn, d, sum, den, l, s, hue, n, t1, t2, third, grey;
        t_rgb px;
        r = r8; g = g8; b = b8;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        l = (sum * ONE) / 510;
        den = (sum <= 255) ? sum : 510 - sum;
        s = (den == 0) ? 0 : (d * ONE) / den;
        hue = 0;
        if (s > 0 && d > 0) begin
            // ties for the max favor red, then green
            if (mx == r)      n = g - b;
            else if (mx == g) n = 2 * d + b - r;
            else              n = 4 * d + r - g;
            if (n < 0) n += 6 * d;
            hue = (n * ONE) / (6 * d);
        end
        if (cur_mode == hsl_pkg::MODE_LIGHTEN) begin
            l += cur_delta;
            if (l < 0) l = 0;
            if (l > ONE) l = ONE;
        end else begin
            hue = (hue + ONE / 2) & (ONE - 1);
        end
        if (s == 0) begin
            grey = (l * 255) >>> FB;
            px.red   = hsl_pkg::t_pix'(grey);
            px.green = hsl_pkg::t_pix'(grey);
            px.blue  = hsl_pkg::t_pix'(grey);
        end else begin
            third = ONE / 3;
            if (2 * l < ONE) t1 = (l * (ONE + s)) >>> FB;
            else             t1 = l + s - ((l * s) >>> FB);
            t2 = 2 * l - t1;
            if (t2 < 0) t2 = 0;
            px.red   = hue_to_channel(hue + third, t1, t2);
            px.green = hue_to_channel(hue, t1, t2);
            px.blue  = hue_to_channel(hue - third, t1, t2);
        end
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Output side: stall at random or on request, and compare each item.
    initial begin
        t_rgb want;
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_red_out !== want.red)     report_mismatch("red", o_red_out, want.red);
                    if (o_green_out !== want.green)
                        report_mismatch("green", o_green_out, want.green);
                    if (o_blue_out !== want.blue)   report_mismatch("blue", o_blue_out, want.blue);
                end
            end
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one pixel and hold it until accepted; record its prediction.
    // Valid stays high afterwards; the next pixel, a gap or a drain replaces it.
    task automatic send_pixel(hsl_pkg::t_pix r, hsl_pkg::t_pix g, hsl_pkg::t_pix b);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        expected_pixels.push_back(adjust_pixel(r, g, b));
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Write a register while the block is idle.
    task automatic write_reg(hsl_pkg::t_cfg_idx idx, longint value);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[hsl_pkg::DELTA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == hsl_pkg::CFG_MODE) cur_mode = hsl_pkg::t_mode'(value[0]);
        else                          cur_delta = $signed(value[hsl_pkg::DELTA_W-1:0]);
    endtask

    task automatic send_random_pixel();
        case ($urandom_range(0, 5))
            0: begin
                // grey pixel
                hsl_pkg::t_pix v;
                v = hsl_pkg::t_pix'($urandom);
                send_pixel(v, v, v);
            end
            1: send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, hsl_pkg::t_pix'($urandom),
                          $urandom_range(0, 1) ? 8'hFF : 8'h00);
            default: send_pixel(hsl_pkg::t_pix'($urandom), hsl_pkg::t_pix'($urandom),
                                hsl_pkg::t_pix'($urandom));
        endcase
    endtask

    // Corners: black, white, primaries, ties for the max, near-grey, hue wrap.
    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd10, 8'd60);
        send_pixel(8'd127, 8'd128, 8'd128);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd85, 8'd170, 8'd255);
        send_pixel(8'd100, 8'd50, 8'd200);
    endtask

    task automatic test_settings();
        longint deltas[7];
        deltas = '{-65536, 65536, -131072, 131071, 12345, -40000, 0};
        foreach (deltas[k]) begin
            write_reg(hsl_pkg::CFG_DELTA, deltas[k]);
            test_directed();
            repeat (40) send_random_pixel();
        end
        write_reg(hsl_pkg::CFG_MODE, hsl_pkg::MODE_INVERT);
        write_reg(hsl_pkg::CFG_DELTA, 30000);  // ignored in invert mode
        test_directed();
        repeat (60) send_random_pixel();
    endtask

    // Stall the output long enough that the pipeline fills and input backs up.
    task automatic test_backpressure();
        sink_hold_cycles = 3 * LATENCY + 20;
        repeat (2 * LATENCY + 10) send_random_pixel();
        drain_pipeline();
    endtask

    task automatic test_random();
        int k;
        for (k = 0; k < 400; k++) begin
            if (k % 100 == 0) begin
                write_reg(hsl_pkg::CFG_MODE, $urandom_range(0, 1));
                write_reg(hsl_pkg::CFG_DELTA, longint'($urandom_range(0, 131072)) - 65536);
            end
            send_random_pixel();
        end
        // final stretch at full rate, no idling
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (150) send_random_pixel();
    endtask

    initial begin
        error_count      = 0;
        sink_idle_on     = 1'b1;
        src_idle_on      = 1'b1;
        sink_hold_cycles = 0;
        cur_mode         = hsl_pkg::MODE_LIGHTEN;
        cur_delta        = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = hsl_pkg::CFG_MODE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_out_ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();          // reset values: lighten with zero offset
        write_reg(hsl_pkg::CFG_MODE, hsl_pkg::MODE_LIGHTEN);
        test_settings();
        write_reg(hsl_pkg::CFG_MODE, hsl_pkg::MODE_LIGHTEN);
        test_backpressure();
        test_random();

        drain_pipeline();
        if (error_count == 0)
            $display("PASS hsl_lightness_hue_adjust");
        else
            $display("FAIL hsl_lightness_hue_adjust");
        $finish;
    end
endmodule
